@@ rtl/isiu_pkg.sv @@
package isiu_pkg;

  localparam int unsigned InDataBits  = 32;
  localparam int unsigned OutDataBits = 40;
  localparam int unsigned FieldBits   = 32;
  localparam int unsigned PosBits     = 6;

  // controller -> datapath
  typedef struct packed {
    logic insert;
    logic drain;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_slot;
    logic one_left;
  } status_t;

endpackage

@@ rtl/isiu_datapath.sv @@
module isiu_datapath #(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  isiu_pkg::cmd_t                    cmd_i,
  input  logic [VALUE_BITS-1:0]             value_i,
  output isiu_pkg::status_t                 status_o,
  output logic [VALUE_BITS-1:0]             head_value_o,
  output logic [isiu_pkg::PosBits-1:0]      head_pos_o
);

  localparam int unsigned CntBits = $clog2(MAX_ITEMS + 1);

  logic [VALUE_BITS-1:0]        val_q [MAX_ITEMS];
  logic [isiu_pkg::PosBits-1:0] pos_q [MAX_ITEMS];
  logic [CntBits-1:0]           count_q, count_d;
  logic [MAX_ITEMS-1:0]         gt;
  logic [isiu_pkg::PosBits-1:0] new_pos;

  assign new_pos = isiu_pkg::PosBits'(count_q);

  // one comparator per cell; a set bit means the cell moves up to make room
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      gt[i] = (CntBits'(i) < count_q) && ($signed(val_q[i]) > $signed(value_i));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (cmd_i.insert) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          val_q[i] <= val_q[(i > 0) ? i - 1 : 0];
          pos_q[i] <= pos_q[(i > 0) ? i - 1 : 0];
        end else if (gt[i] || CntBits'(i) == count_q) begin
          val_q[i] <= value_i;
          pos_q[i] <= new_pos;
        end
      end else if (cmd_i.drain && i < MAX_ITEMS - 1) begin
        val_q[i] <= val_q[(i < MAX_ITEMS - 1) ? i + 1 : i];
        pos_q[i] <= pos_q[(i < MAX_ITEMS - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CntBits'(1);
    end else if (cmd_i.drain) begin
      count_d = count_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign status_o.last_slot = (count_q == CntBits'(MAX_ITEMS - 1));
  assign status_o.one_left  = (count_q == CntBits'(1));
  assign head_value_o       = val_q[0];
  assign head_pos_o         = pos_q[0];

endmodule

@@ rtl/isiu_ctrl.sv @@
module isiu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  isiu_pkg::status_t  status_i,
  output isiu_pkg::cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o.insert = 1'b0;
    cmd_o.drain  = 1'b0;
    unique case (state_q)
      ST_FILL: begin
        in_ready_o   = 1'b1;
        cmd_o.insert = in_valid_i;
        if (in_valid_i && (in_last_i || status_i.last_slot)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        out_valid_o = 1'b1;
        cmd_o.drain = out_ready_i;
        if (out_ready_i && status_i.one_left) begin
          state_d = ST_FILL;
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/insertion_sort_with_index_unit.sv @@
// Insert: one input transaction per cycle while a set is being filled; each
// value lands in its sorted place in the cell row in the cycle it is taken.
// Drain: results start the cycle after the closing transaction, one per cycle
// when m_axis_tready is high; a set of n values gives n results, and
// no input is taken meanwhile. Reset clears the fill count and controller;
// cell contents are left as they are.
module insertion_sort_with_index_unit #(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [isiu_pkg::InDataBits-1:0]     s_axis_tdata_i,  // [31:0] value
  input  logic                                s_axis_tlast_i,  // is_last
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [31:0] sorted_value, [37:32] original_position, [39:38] zero
  output logic [isiu_pkg::OutDataBits-1:0]    m_axis_tdata_o,
  output logic                                m_axis_tlast_o   // end_of_run
);

  isiu_pkg::cmd_t               cmd;
  isiu_pkg::status_t            status;
  logic [63:0]                  in_wide;
  logic [63:0]                  out_wide;
  logic [VALUE_BITS-1:0]        in_value;
  logic [VALUE_BITS-1:0]        head_value;
  logic [isiu_pkg::PosBits-1:0] head_pos;

  // bits above VALUE_BITS are dropped; results are zero-extended
  assign in_wide  = 64'(s_axis_tdata_i[isiu_pkg::FieldBits-1:0]);
  assign in_value = in_wide[VALUE_BITS-1:0];
  assign out_wide = 64'(head_value);

  isiu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  isiu_datapath #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (in_value),
    .status_o     (status),
    .head_value_o (head_value),
    .head_pos_o   (head_pos)
  );

  assign m_axis_tdata_o = {2'b00, head_pos, out_wide[isiu_pkg::FieldBits-1:0]};
  assign m_axis_tlast_o = status.one_left;

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input and output sides open together");

  a_close_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> m_axis_tvalid_o)
    else $error("closing transaction did not start the drain");

  a_run_end_refills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("end of run did not reopen the input");

  a_no_insert_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.insert && cmd.drain))
    else $error("insert and drain commanded together");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int unsigned SetDepth   = 64;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned RandItems  = 240;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  position;
    logic        end_of_run;
  } sorted_entry_t;

  // Keeps its own copy of the set in ascending order and queues the drained
  // order once a set closes.
  class sort_scoreboard;
    logic [31:0]   held_values [SetDepth];
    logic [5:0]    held_positions [SetDepth];
    int unsigned   held_count  = 0;
    sorted_entry_t sorted_expect[$];
    int unsigned   errors      = 0;
    int unsigned   items_in    = 0;
    int unsigned   results_ok  = 0;
    int unsigned   sets_closed = 0;
    int unsigned   full_closes = 0;

    function void note_item(logic [31:0] value, logic last);
      int unsigned   n;
      int unsigned   slot;
      sorted_entry_t entry;
      n = held_count;
      if (n >= SetDepth) n = 0;
      slot = n;
      // stable: only strictly greater entries move up
      while (slot > 0 && $signed(value) < $signed(held_values[slot-1])) begin
        held_values[slot]    = held_values[slot-1];
        held_positions[slot] = held_positions[slot-1];
        slot--;
      end
      held_values[slot]    = value;
      held_positions[slot] = 6'(n);
      n++;
      items_in++;
      if (!last && n < SetDepth) begin
        held_count = n;
      end else begin
        if (!last) full_closes++;
        sets_closed++;
        for (int unsigned k = 0; k < n; k++) begin
          entry.value      = held_values[k];
          entry.position   = held_positions[k];
          entry.end_of_run = (k + 1 == n);
          sorted_expect.push_back(entry);
        end
        held_count = 0;
      end
    endfunction

    function void check_result(logic [isiu_pkg::OutDataBits-1:0] data, logic last);
      sorted_entry_t want;
      bit            bad;
      bad = 0;
      if (sorted_expect.size() == 0) begin
        $error("unexpected result: sorted_value %0d position %0d end_of_run %0b",
               $signed(data[31:0]), data[37:32], last);
        errors++;
        return;
      end
      want = sorted_expect.pop_front();
      if (data[31:0] !== want.value) begin
        $error("sorted_value: expected %0d, got %0d", $signed(want.value),
               $signed(data[31:0]));
        bad = 1;
      end
      if (data[37:32] !== want.position) begin
        $error("original_position: expected %0d, got %0d", want.position, data[37:32]);
        bad = 1;
      end
      if (last !== want.end_of_run) begin
        $error("end_of_run: expected %0b, got %0b", want.end_of_run, last);
        bad = 1;
      end
      if (data[39:38] !== 2'b00) begin
        $error("tdata padding: expected 0, got %0b", data[39:38]);
        bad = 1;
      end
      if (bad) errors++;
      else results_ok++;
    endfunction

    function int unsigned outstanding();
      return sorted_expect.size();
    endfunction

    function void close_out();
      while (sorted_expect.size() != 0) begin
        $error("missing result: sorted_value %0d position %0d",
               $signed(sorted_expect[0].value), sorted_expect[0].position);
        void'(sorted_expect.pop_front());
        errors++;
      end
    endfunction
  endclass

  logic                              clk_i           = 1'b0;
  logic                              rst_ni          = 1'b0;
  logic                              s_axis_tvalid_i = 1'b0;
  logic                              s_axis_tready_o;
  logic [isiu_pkg::InDataBits-1:0]   s_axis_tdata_i  = '0;  // [31:0] value
  logic                              s_axis_tlast_i  = 1'b0;  // is_last
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i = 1'b0;
  // [31:0] sorted_value, [37:32] original_position, [39:38] zero
  logic [isiu_pkg::OutDataBits-1:0]  m_axis_tdata_o;
  logic                              m_axis_tlast_o;  // end_of_run

  sort_scoreboard sb = new();

  int unsigned cycle_count     = 0;
  int unsigned burst_left      = 0;
  int unsigned hold_requested  = 0;
  int unsigned hold_served     = 0;
  int unsigned hold_left       = 0;
  int unsigned rx_mode         = 0;
  int unsigned rx_mode_left    = 0;
  int unsigned rand_sent       = 0;
  int unsigned set_idx         = 0;
  int unsigned set_size        = 0;
  logic        close_flag;

  insertion_sort_with_index_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.outstanding());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Transactions are sampled at the edge, before anything driven there lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) sb.note_item(s_axis_tdata_i[31:0], s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  // Receiver: a long hold-off on request, otherwise a changing stall pattern.
  always @(posedge clk_i) begin
    if (hold_served != hold_requested) begin
      hold_served++;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 60);
      end
      rx_mode_left--;
      case (rx_mode)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= 1'($urandom_range(0, 1));
        2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready_i <= cycle_count[1];
      endcase
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return 32'($urandom_range(0, 8)) - 32'd4;  // many duplicates
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [31:0] value, input logic last);
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= $urandom;
      s_axis_tlast_i  <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, equal values in arrival order, a one-element set
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'd5,         1'b0);
    send_item(32'd5,         1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b1);
    send_item(32'h1234_5678, 1'b1);
    for (int i = 0; i < 6; i++) send_item(32'd100 - 32'(i * 7), i == 5);
    for (int i = 0; i < 4; i++) send_item(32'hFFFF_FFF0 + 32'(i), i == 3);
    wait_drained();

    // random sets: mostly short, a few that fill the store
    while (rand_sent < RandItems) begin
      if (set_idx == 2 || set_idx == 5 || $urandom_range(0, 11) == 0) set_size = SetDepth;
      else set_size = $urandom_range(1, 12);
      if (set_size > RandItems - rand_sent) set_size = RandItems - rand_sent;
      // receiver blocks the drain while the next set is already offered
      if (set_idx == 3) hold_requested++;
      if (set_idx == 7) wait_drained();
      for (int unsigned k = 0; k < set_size; k++) begin
        if (k + 1 < set_size) close_flag = 1'b0;
        else if (set_size < SetDepth || set_idx == 5) close_flag = 1'b1;
        else if (set_idx == 2) close_flag = 1'b0;
        else close_flag = 1'($urandom_range(0, 1));
        send_item(pick_value(), close_flag);
        rand_sent++;
      end
      set_idx++;
    end
    wait_drained();
    repeat (20) @(posedge clk_i);

    sb.close_out();
    $display("%0d values in %0d sets (%0d closed by a full store), %0d results matched",
             sb.items_in, sb.sets_closed, sb.full_closes, sb.results_ok);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
